// ===== hw/rtl/cfpw_pkg.sv =====
// Shared types and constants for the card frame parser with whitelist.
package cfpw_pkg;

  localparam int unsigned HeaderLen = 7;
  localparam int unsigned FrameEnd  = 10;
  localparam int unsigned PosW      = 4;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_ARM  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    OUT_MATCHED  = 2'd0,
    OUT_NO_MATCH = 2'd1,
    OUT_ENROLLED = 2'd2,
    OUT_FULL     = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input word taken this cycle
    logic scan_run;   // step the store scan
    logic scan_end;   // latch match / no-match result
    logic load_out;   // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_end;  // current input word is the last ID byte
    logic armed;
    logic scan_hit;
    logic scan_miss;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] header_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h04;
      3'd1:    b = 8'h0C;
      3'd2:    b = 8'h02;
      3'd3:    b = 8'h30;
      3'd4:    b = 8'h00;
      3'd5:    b = 8'h04;
      3'd6:    b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/cfpw_in_if.sv =====
// Input channel: reader byte or enrollment arm request.
interface cfpw_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// ===== hw/rtl/cfpw_out_if.sv =====
// Output channel: frame result word.
interface cfpw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [3:0]  card_index;
  logic [31:0] card_id;

  modport source (output valid, output outcome, output card_index, output card_id,
                  input ready);
  modport sink   (input valid, input outcome, input card_index, input card_id,
                  output ready);
endinterface

// ===== hw/rtl/cfpw_ctrl.sv =====
// Control state machine: accept, store scan, result hand-off.
module cfpw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cfpw_pkg::sts_t   sts_i,
  output cfpw_pkg::cmd_t   cmd_o
);

  cfpw_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == cfpw_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      cfpw_pkg::ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.frame_end) begin
          state_d = sts_i.armed ? cfpw_pkg::ST_EMIT : cfpw_pkg::ST_SCAN;
        end
      end
      cfpw_pkg::ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_hit || sts_i.scan_miss) begin
          cmd_o.scan_end = 1'b1;
          state_d        = cfpw_pkg::ST_EMIT;
        end
      end
      cfpw_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = cfpw_pkg::ST_IDLE;
        end
      end
      default: state_d = cfpw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfpw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/cfpw_dp.sv =====
// Datapath: header parser, ID capture, card store and scan, output register.
module cfpw_dp #(
  parameter int unsigned MAX_CARDS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfpw_pkg::cmd_t cmd_i,
  output cfpw_pkg::sts_t sts_o,
  input  logic           in_operation_i,
  input  logic [7:0]     in_rx_byte_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [1:0]     out_outcome_o,
  output logic [3:0]     out_card_index_o,
  output logic [31:0]    out_card_id_o
);

  localparam int unsigned IdxW = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
  localparam int unsigned CntW = $clog2(MAX_CARDS + 1);

  logic [cfpw_pkg::PosW-1:0] pos_q, pos_d;
  logic [23:0]               cap_q;
  logic [CntW-1:0]           cnt_q;
  logic                      armed_q;
  logic [31:0]               id_q;
  logic [CntW-1:0]           idx_q;
  logic [31:0]               rd_q;
  logic                      rd_vld_q;
  logic [IdxW-1:0]           rd_idx_q;
  cfpw_pkg::outcome_e        res_outcome_q;
  logic [3:0]                res_index_q;
  logic                      out_valid_q;
  cfpw_pkg::outcome_e        out_outcome_q;
  logic [3:0]                out_index_q;
  logic [31:0]               out_id_q;

  logic [31:0] mem [MAX_CARDS];

  logic            is_byte, frame_acc, has_room, wr_en, rd_en, more;
  logic [31:0]     frame_id;
  logic [IdxW+3:0] cnt_ext, rd_idx_ext;

  assign is_byte    = (in_operation_i == cfpw_pkg::OP_BYTE);
  assign frame_id   = {cap_q, in_rx_byte_i};
  assign has_room   = (cnt_q < CntW'(MAX_CARDS));
  assign frame_acc  = cmd_i.accept && sts_o.frame_end;
  assign wr_en      = frame_acc && armed_q && has_room;
  assign more       = (idx_q < cnt_q);
  assign rd_en      = cmd_i.scan_run && more;
  // slot numbers wider than the field keep their low four bits
  assign cnt_ext    = {4'b0, cnt_q[IdxW-1:0]};
  assign rd_idx_ext = {4'b0, rd_idx_q};

  assign sts_o.frame_end = is_byte && (pos_q == cfpw_pkg::PosW'(cfpw_pkg::FrameEnd));
  assign sts_o.armed     = armed_q;
  assign sts_o.scan_hit  = rd_vld_q && (rd_q == id_q);
  assign sts_o.scan_miss = !rd_vld_q && !more;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // header / ID position
  always_comb begin
    pos_d = pos_q;
    if (pos_q < cfpw_pkg::PosW'(cfpw_pkg::HeaderLen)) begin
      pos_d = (in_rx_byte_i == cfpw_pkg::header_byte(pos_q[2:0])) ? pos_q + 1'b1 : '0;
    end else if (pos_q < cfpw_pkg::PosW'(cfpw_pkg::FrameEnd)) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cnt_q       <= '0;
      armed_q     <= 1'b0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (rd_en) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.accept) begin
        if (!is_byte) begin
          armed_q <= 1'b1;
        end else begin
          pos_q <= pos_d;
        end
        if (frame_acc) begin
          idx_q   <= '0;
          armed_q <= 1'b0;
          if (wr_en) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_byte && pos_q >= cfpw_pkg::PosW'(cfpw_pkg::HeaderLen)
        && pos_q < cfpw_pkg::PosW'(cfpw_pkg::FrameEnd)) begin
      cap_q <= {cap_q[15:0], in_rx_byte_i};
    end
    if (frame_acc) begin
      id_q <= frame_id;
      if (armed_q) begin
        res_outcome_q <= has_room ? cfpw_pkg::OUT_ENROLLED : cfpw_pkg::OUT_FULL;
        res_index_q   <= has_room ? cnt_ext[3:0] : 4'd0;
      end
    end
    if (cmd_i.scan_end) begin
      res_outcome_q <= sts_o.scan_hit ? cfpw_pkg::OUT_MATCHED : cfpw_pkg::OUT_NO_MATCH;
      res_index_q   <= sts_o.scan_hit ? rd_idx_ext[3:0] : 4'd0;
    end
    if (rd_en) begin
      rd_idx_q <= idx_q[IdxW-1:0];
    end
    if (cmd_i.load_out) begin
      out_outcome_q <= res_outcome_q;
      out_index_q   <= res_index_q;
      out_id_q      <= id_q;
    end
  end

  // card store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IdxW-1:0]] <= frame_id;
    end
    if (rd_en) begin
      rd_q <= mem[idx_q[IdxW-1:0]];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_outcome_o    = out_outcome_q;
  assign out_card_index_o = out_index_q;
  assign out_card_id_o    = out_id_q;

endmodule

// ===== hw/rtl/card_frame_parser_whitelist.sv =====
// Top level: card reader frame parser with enrollment and whitelist lookup.
// Throughput: one input word per cycle except after the last ID byte of a frame.
// Enrolled or table-full frame: result is loaded into the output register when free.
// Lookup frame: the single store read port walks the stored slots in order until a
//   match or the last stored card; input is held off until the result is queued.
// Reset (async, active low) clears parser, count and arm flag; the store needs no clear.
module card_frame_parser_whitelist #(
  parameter int unsigned MAX_CARDS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfpw_in_if.sink    in_i,
  cfpw_out_if.source out_o
);

  cfpw_pkg::cmd_t cmd;
  cfpw_pkg::sts_t sts;

  // FSM decides when words are taken and when the scan runs
  cfpw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // parser, store and output register; the output register lets the
  // next frame's bytes flow in while a result waits for the sink
  cfpw_dp #(
    .MAX_CARDS (MAX_CARDS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_operation_i   (in_i.operation),
    .in_rx_byte_i     (in_i.rx_byte),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_outcome_o    (out_o.outcome),
    .out_card_index_o (out_o.card_index),
    .out_card_id_o    (out_o.card_id)
  );

endmodule

// ===== hw/rtl/cfpw_checker.sv =====
// Port-level checks for the card frame parser, bound to the top level.
module cfpw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_operation_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_outcome_i,
  input logic [3:0]  out_card_index_i,
  input logic [31:0] out_card_id_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_outcome_i) && $stable(out_card_index_i)
                                    && $stable(out_card_id_i))
    else $error("stalled result word changed");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_outcome_i == cfpw_pkg::OUT_NO_MATCH ||
                    out_outcome_i == cfpw_pkg::OUT_FULL) |-> out_card_index_i == 4'd0)
    else $error("nonzero index on no-match or full");

  a_arm_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_operation_i == cfpw_pkg::OP_ARM && !out_valid_i
      |=> !out_valid_i)
    else $error("arm request produced a result");

endmodule

bind card_frame_parser_whitelist cfpw_checker u_cfpw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_operation_i   (in_i.operation),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_outcome_i    (out_o.outcome),
  .out_card_index_i (out_o.card_index),
  .out_card_id_i    (out_o.card_id)
);

// ===== test/card_frame_parser_whitelist_test.sv =====
// Self-checking testbench for the card frame parser with whitelist.
module card_frame_parser_whitelist_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCards   = 16;
  localparam int unsigned WordTarget = 1600;
  // Quiet tail: no idling on either side once this many words are in.
  localparam int unsigned CalmAfter  = 1350;
  // The limit covers the worst case per word (sender gap, a lookup over all
  // MaxCards slots, receiver stall) over the whole run, several times over.
  localparam int unsigned CycleLimit = 400000;

  // Frame header, expected in this order before the four ID bytes.
  localparam logic [7:0] HeaderSeq [cfpw_pkg::HeaderLen] =
    '{8'h04, 8'h0C, 8'h02, 8'h30, 8'h00, 8'h04, 8'h00};

  typedef struct {
    cfpw_pkg::outcome_e outcome;
    logic [3:0]         index;
    logic [31:0]        id;
  } card_result_t;

  // One row of the directed part. Rows with a typed answer carry it here;
  // all others are checked through the predictor.
  typedef struct {
    cfpw_pkg::op_e op;
    logic [7:0]    data;
    bit            typed;
    card_result_t  answer;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cfpw_in_if  in_if();
  cfpw_out_if out_if();

  card_frame_parser_whitelist #(
    .MAX_CARDS(MaxCards)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor state: mirrors the parser, the card table and the arm flag.
  // ---------------------------------------------------------------------
  int unsigned  frame_pos;
  logic [23:0]  id_bytes;
  logic [31:0]  whitelist [MaxCards];
  int unsigned  enrolled;
  bit           arm_pending;

  card_result_t results_due[$];
  card_result_t want;
  int unsigned  failures;
  int unsigned  words_sent;
  int unsigned  cycles;
  bit           gaps_on;
  int unsigned  stall_left;

  // Advance the predictor by one accepted word. made is set when the word
  // closes a frame; r then holds the expected result.
  task automatic track_word(input cfpw_pkg::op_e op, input logic [7:0] b,
                            output bit made, output card_result_t r);
    bit hit;
    made = 1'b0;
    hit  = 1'b0;
    r.outcome = cfpw_pkg::OUT_NO_MATCH;
    r.index   = 4'd0;
    r.id      = 32'd0;
    if (op == cfpw_pkg::OP_ARM) begin
      // Arm leaves parser position and captured bytes alone.
      arm_pending = 1'b1;
    end else if (frame_pos < cfpw_pkg::HeaderLen) begin
      // A wrong header byte drops back to the start and is not retried
      // as a first header byte.
      frame_pos = (b == HeaderSeq[frame_pos]) ? frame_pos + 1 : 0;
    end else if (frame_pos < cfpw_pkg::FrameEnd) begin
      id_bytes  = {id_bytes[15:0], b};
      frame_pos = frame_pos + 1;
    end else begin
      made      = 1'b1;
      frame_pos = 0;
      r.id      = {id_bytes, b};
      if (arm_pending) begin
        arm_pending = 1'b0;
        if (enrolled < MaxCards) begin
          whitelist[enrolled] = r.id;
          r.outcome = cfpw_pkg::OUT_ENROLLED;
          r.index   = enrolled[3:0];
          enrolled++;
        end else begin
          r.outcome = cfpw_pkg::OUT_FULL;
        end
      end else begin
        // Lowest matching slot wins; duplicates sit in higher slots.
        for (int unsigned i = 0; i < enrolled; i++) begin
          if (!hit && whitelist[i] == r.id) begin
            hit       = 1'b1;
            r.outcome = cfpw_pkg::OUT_MATCHED;
            r.index   = i[3:0];
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Input driver. Called at a falling edge, returns at a falling edge.
  // valid stays high across back-to-back words and is only dropped for
  // an idle burst, so it never sees two updates in one time step.
  // ---------------------------------------------------------------------
  task automatic send_word(input cfpw_pkg::op_e op, input logic [7:0] b,
                           input bit typed, input card_result_t answer);
    bit           made;
    card_result_t r;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.rx_byte   <= b;
    do @(posedge clk_i); while (!in_if.ready);
    track_word(op, b, made, r);
    if (made) results_due.push_back(typed ? answer : r);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    card_result_t none;
    none = '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0};
    send_word(cfpw_pkg::OP_BYTE, b, 1'b0, none);
  endtask

  task automatic send_arm();
    card_result_t none;
    none = '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0};
    // rx_byte is don't-care on an arm word; keep it random.
    send_word(cfpw_pkg::OP_ARM, 8'($urandom), 1'b0, none);
  endtask

  // Well-formed frame, with a rare arm word slipped in before or between bytes.
  task automatic send_frame(input logic [31:0] id);
    logic [7:0] seq [cfpw_pkg::FrameEnd + 1];
    for (int i = 0; i < cfpw_pkg::HeaderLen; i++) seq[i] = HeaderSeq[i];
    for (int i = 0; i < 4; i++) seq[cfpw_pkg::HeaderLen + i] = id[31 - 8*i -: 8];
    for (int i = 0; i <= cfpw_pkg::FrameEnd; i++) begin
      if ($urandom_range(0, 59) == 0) send_arm();
      send_byte(seq[i]);
    end
  endtask

  // Header cut short by a wrong byte at a random position; 0x04 is a
  // favorite wrong byte since it must not restart the header.
  task automatic send_broken_header();
    int unsigned cut;
    logic [7:0]  bad;
    cut = $urandom_range(1, cfpw_pkg::HeaderLen - 1);
    for (int unsigned i = 0; i < cut; i++) send_byte(HeaderSeq[i]);
    do bad = ($urandom_range(0, 2) == 0) ? 8'h04 : 8'($urandom);
    while (bad == HeaderSeq[cut]);
    send_byte(bad);
  endtask

  function automatic logic [31:0] pick_id();
    int unsigned k;
    if (enrolled != 0 && $urandom_range(0, 9) < 4) begin
      return whitelist[$urandom_range(0, enrolled - 1)];
    end
    k = $urandom_range(0, 9);
    case (k)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h040C_0230;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Directed part: arm handling, header resync, the two extreme IDs.
  // ---------------------------------------------------------------------
  localparam int unsigned PlanLen = 28;
  plan_row_t plan [PlanLen] = '{
    '{cfpw_pkg::OP_ARM,  8'h00, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_ARM,  8'hFF, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},  // re-arm
    // 04 0C then 04: wrong byte drops to start, then 0C keeps it there
    '{cfpw_pkg::OP_BYTE, 8'h04, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h0C, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h04, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h0C, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    // armed frame, all-zero ID: lands in slot 0
    '{cfpw_pkg::OP_BYTE, 8'h04, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h0C, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h02, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h30, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h00, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h04, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h00, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h00, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h00, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h00, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h00, 1'b1, '{cfpw_pkg::OUT_ENROLLED, 4'd0, 32'h0000_0000}},
    // unarmed frame, all-ones ID: not in the table
    '{cfpw_pkg::OP_BYTE, 8'h04, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h0C, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h02, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h30, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h00, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h04, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'h00, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'hFF, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'hFF, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'hFF, 1'b0, '{cfpw_pkg::OUT_MATCHED, 4'd0, 32'd0}},
    '{cfpw_pkg::OP_BYTE, 8'hFF, 1'b1, '{cfpw_pkg::OUT_NO_MATCH, 4'd0, 32'hFFFF_FFFF}}
  };

  // ---------------------------------------------------------------------
  // Receiver: ready stalls in random bursts, changed at the falling edge.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 8);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result check: every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none expected: outcome %0d index %0d id %h",
                 $time, out_if.outcome, out_if.card_index, out_if.card_id);
        failures++;
      end else begin
        want = results_due.pop_front();
        if (out_if.outcome !== want.outcome) begin
          $display("%0t: outcome expected %0d got %0d",
                   $time, want.outcome, out_if.outcome);
          failures++;
        end
        if (out_if.card_index !== want.index) begin
          $display("%0t: card_index expected %0d got %0d",
                   $time, want.index, out_if.card_index);
          failures++;
        end
        if (out_if.card_id !== want.id) begin
          $display("%0t: card_id expected %h got %h",
                   $time, want.id, out_if.card_id);
          failures++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned pick;
    in_if.valid     = 1'b0;
    in_if.operation = cfpw_pkg::OP_BYTE;
    in_if.rx_byte   = 8'h00;
    out_if.ready    = 1'b0;
    frame_pos   = 0;
    id_bytes    = '0;
    enrolled    = 0;
    arm_pending = 1'b0;
    failures    = 0;
    words_sent  = 0;
    cycles      = 0;
    stall_left  = 0;
    gaps_on     = 1'b1;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_word(plan[i].op, plan[i].data, plan[i].typed, plan[i].answer);

    // Random part: mostly clean frames (some armed) so the table fills,
    // overflows and gets matched; the rest is broken headers, noise and lone arm words.
    while (words_sent < WordTarget) begin
      if (words_sent > CalmAfter) gaps_on = 1'b0;
      else if ($urandom_range(0, 15) == 0) gaps_on = ~gaps_on;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 3) == 0) send_arm();
        send_frame(pick_id());
      end else if (pick < 85) begin
        send_broken_header();
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end else begin
        send_arm();
      end
    end
    in_if.valid <= 1'b0;

    // Drain, then wait long enough for a full lookup to bring out any stray result.
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (MaxCards + 16) @(posedge clk_i);

    if (failures == 0 && results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cfpw_pkg.sv
hw/rtl/cfpw_in_if.sv
hw/rtl/cfpw_out_if.sv
hw/rtl/cfpw_ctrl.sv
hw/rtl/cfpw_dp.sv
hw/rtl/card_frame_parser_whitelist.sv
hw/rtl/cfpw_checker.sv
test/card_frame_parser_whitelist_test.sv
